### hdl/bfst_pkg.sv
// Shared types and constants for the best-fit free space table.
`timescale 1ns / 1ps

package bfst_pkg;

    // Field widths
    localparam int AMT_W = 24;
    localparam int IDX_W = 8;

    // Item kinds
    typedef enum logic [0:0] {
        CMD_UPDATE = 1'b0,
        CMD_QUERY  = 1'b1
    } cmd_t;

    // Control sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Control from the sequencer to the best-fit tracker
    typedef struct packed {
        logic             start;   // new item: drop the running best
        logic             vld;     // table read data is valid this cycle
        logic [IDX_W-1:0] idx;     // entry that the read data belongs to
    } scan_ctl_t;

endpackage

### hdl/bfst_req_if.sv
// Request channel: valid/ready handshake carrying one command word.
`timescale 1ns / 1ps

interface bfst_req_if
    import bfst_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [IDX_W-1:0] block_index;
    logic [AMT_W-1:0] amount;

    modport source (output valid, output cmd, output block_index, output amount,
                    input ready);
    modport sink   (input valid, input cmd, input block_index, input amount,
                    output ready);
endinterface

### hdl/bfst_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
`timescale 1ns / 1ps

interface bfst_rsp_if
    import bfst_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] best_index;

    modport source (output valid, output found, output best_index, input ready);
    modport sink   (input valid, input found, input best_index, output ready);
endinterface

### hdl/bfst_best.sv
// Running best-fit tracker fed by the table read port during a query scan.
`timescale 1ns / 1ps

module bfst_best
    import bfst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  scan_ctl_t        ctl,
    input  logic [AMT_W-1:0] want,
    input  logic [AMT_W-1:0] data,
    output logic             have,
    output logic [IDX_W-1:0] best_idx
);

    logic             have_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [AMT_W-1:0] best_val_reg;
    logic             take;

    // Entry fits and is strictly tighter; equal values keep the lower index
    assign take = ctl.vld && (data >= want) && (!have_reg || (data < best_val_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg     <= 1'b0;
            best_idx_reg <= '0;
        end
        else if (ctl.start)
        begin
            have_reg     <= 1'b0;
            best_idx_reg <= '0;
        end
        else if (take)
        begin
            have_reg     <= 1'b1;
            best_idx_reg <= ctl.idx;
        end
    end

    // Value of the current best, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_val_reg <= data;
        end
    end

    assign have     = have_reg;
    assign best_idx = best_idx_reg;

endmodule

### hdl/best_fit_free_space_table.sv
// Top level of the best-fit free space table: sequencer, table memory, output register.
//
//   channel | dir | word fields                        | handshake
//   --------+-----+------------------------------------+-------------
//   req     | in  | cmd, block_index, amount           | valid/ready
//   rsp     | out | found, best_index                  | valid/ready
//
// One word is worked on at a time. A query reads the table memory one entry per cycle
// over its single read port, from entry 0 up to blocks_in_use - 1. An update inside
// the count writes its entry on accept; one that grows the count zeroes the skipped
// entries one per cycle through the write port, then writes the new amount.
// Reset clears the count, not the table; entries at or past the count are never read.
// The result register lets a new word in while the last result waits on rsp.
`timescale 1ns / 1ps

module best_fit_free_space_table
    import bfst_pkg::*;
#(
    parameter int MAX_BLOCKS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    bfst_req_if.sink    req,
    bfst_rsp_if.source  rsp
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    // Control state
    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic [CW-1:0]    target_reg, target_next;
    logic [AMT_W-1:0] arg_reg, arg_next;

    // Table memory
    logic [AMT_W-1:0] mem [MAX_BLOCKS];
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AMT_W-1:0] wr_data;
    logic             rd_issue;
    logic [AMT_W-1:0] rd_data_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    // Output register
    logic             out_valid_reg;
    logic             out_found_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic             out_load;

    logic             accept;
    logic [XW-1:0]    idx_x;
    logic [XW-1:0]    ptr_x;
    logic             in_range;
    logic             grows;
    logic             have;
    logic [IDX_W-1:0] best_idx;
    scan_ctl_t        scan_ctl;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign idx_x     = XW'(req.block_index);
    assign ptr_x     = XW'(ptr_reg);
    assign in_range  = idx_x < XW'(MAX_BLOCKS);
    assign grows     = idx_x >= XW'(count_reg);

    // Sequencer: next state and memory controls
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        target_next = target_reg;
        arg_next    = arg_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_x[AW-1:0];
        wr_data     = req.amount;
        rd_issue    = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    arg_next = req.amount;
                    if (cmd_t'(req.cmd) == CMD_QUERY)
                    begin
                        ptr_next   = '0;
                        state_next = (count_reg == '0) ? ST_DONE : ST_SCAN;
                    end
                    else if (!in_range)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (grows)
                    begin
                        ptr_next    = count_reg;
                        target_next = idx_x[CW-1:0];
                        state_next  = ST_CLEAR;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CLEAR:
            begin
                // zero the skipped entries, then write the new amount
                wr_en   = 1'b1;
                wr_addr = ptr_reg[AW-1:0];
                wr_data = (ptr_reg == target_reg) ? arg_reg : '0;
                if (ptr_reg == target_reg)
                begin
                    count_next = CW'(target_reg + 1'b1);
                    state_next = ST_DONE;
                end
                else
                begin
                    ptr_next = CW'(ptr_reg + 1'b1);
                end
            end
            ST_SCAN:
            begin
                rd_issue = 1'b1;
                if (ptr_reg == CW'(count_reg - 1'b1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    ptr_next = CW'(ptr_reg + 1'b1);
                end
            end
            ST_DRAIN:
            begin
                // last read word is compared this cycle
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ptr_reg    <= '0;
            target_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            target_reg <= target_next;
            rd_vld_reg <= rd_issue;
        end
    end

    // Payload held with the item
    always_ff @(posedge clk)
    begin
        arg_reg <= arg_next;
        if (rd_issue)
        begin
            rd_idx_reg <= ptr_x[IDX_W-1:0];
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_issue)
        begin
            rd_data_reg <= mem[ptr_reg[AW-1:0]];
        end
    end

    // Best-fit tracking
    assign scan_ctl.start = accept;
    assign scan_ctl.vld   = rd_vld_reg;
    assign scan_ctl.idx   = rd_idx_reg;

    bfst_best u_best (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (scan_ctl),
        .want     (arg_reg),
        .data     (rd_data_reg),
        .have     (have),
        .best_idx (best_idx)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_found_reg <= have;
            out_index_reg <= best_idx;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = out_found_reg;
    assign rsp.best_index = out_index_reg;

endmodule

### hdl/bfst_checker.sv
// Port-level checks for the best-fit free space table, bound to the top level.
`timescale 1ns / 1ps

module bfst_checker
    import bfst_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             req_cmd,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             rsp_found,
    input logic [IDX_W-1:0] rsp_best_index
);

    logic       last_update_reg;
    logic [1:0] pend_reg;

    // Kind of the most recently accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_update_reg <= 1'b0;
        end
        else if (req_valid && req_ready)
        begin
            last_update_reg <= (cmd_t'(req_cmd) == CMD_UPDATE);
        end
    end

    // Words accepted whose result has not yet been taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
        end
    end

    // One word at a time: intake closes right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous word still in work");

    // Not found always reports index zero
    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |-> rsp_best_index == '0)
        else $error("not-found result with nonzero index");

    // Updates never report a hit; with one word owed, the shown result is the last word's
    a_update_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && last_update_reg && (pend_reg == 2'd1) |-> !rsp_found)
        else $error("update word produced a found result");

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
            && $stable(rsp_best_index))
        else $error("stalled result changed");

endmodule

bind best_fit_free_space_table bfst_checker u_bfst_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_cmd        (req.cmd),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_found      (rsp.found),
    .rsp_best_index (rsp.best_index)
);
